/* src/double_ended_queue_defines.svh */
// assertion macros used by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// property checked on every clock edge outside reset
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/deq_pkg.sv */
// shared types and constants of the double-ended queue
package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 11;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } t_opcode;

    // moves applied to every cell of the chain together
    typedef struct packed {
        logic data_right;
        logic data_left;
        logic load_back;
        logic mark_right;
        logic mark_left;
    } t_cell_ctl;

endpackage

/* src/double_ended_queue.sv */
// top level of the bounded double-ended queue of signed words
//
// input channel: i_valid / o_stall carry one operation (i_opcode, i_push_value);
// an item is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry one result per operation: popped word,
// pop and drop flags, count, empty and full flags, front and back words.
// the words sit in a row of CAPACITY cells; cell 0 always holds the front and
// a one-hot marker travels with the back, so each push or pop is a single shift of
// the whole row. the back word is picked by an or-tree over the
// marked cells, registered every two levels: S = ceil(log2(CAPACITY)/2) stages.
// a new item is taken only once the last one has reached the result register;
// the next item is taken while a result still waits on a stalled receiver.
// when the receiver stalls, the result register holds; a finished item then
// waits in the block until the register is free, and o_stall stays high.
// reset (synchronous, active low) empties the queue and drops any result;
// stored words are not cleared, only positions held are ever read
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_opcode,
    input  t_word              i_push_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output t_word              o_popped_value,
    output logic               o_pop_ok,
    output logic               o_push_dropped,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic               o_is_empty,
    output logic               o_is_full,
    output t_word              o_front_value,
    output t_word              o_back_value
);

    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int TREE_STAGES = ($clog2(CAPACITY) + 1) / 2;
    localparam int WAIT_W      = $clog2(TREE_STAGES + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [WAIT_W-1:0]  r_wait;
    logic [WAIT_W-1:0]  n_wait;
    logic               r_out_valid;
    logic               n_out_valid;

    // per-item results captured at accept
    t_word              r_job_popped;
    logic               r_job_pop_ok;
    logic               r_job_dropped;

    // result register
    t_word              r_out_popped;
    logic               r_out_pop_ok;
    logic               r_out_dropped;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_empty;
    logic               r_out_full;
    t_word              r_out_front;
    t_word              r_out_back;

    // cell row
    t_word              w_data [CAPACITY];
    logic               w_mark [CAPACITY];
    logic [CAPACITY-1:0][WORD_W-1:0] w_term;
    t_word              w_back;
    t_cell_ctl          w_ctl;

    logic w_accept;
    logic w_finish;
    logic w_empty;
    logic w_full;
    logic w_is_pf;
    logic w_is_pb;
    logic w_is_popf;
    logic w_is_popb;
    logic w_do_pf;
    logic w_do_pb;
    logic w_do_popf;
    logic w_do_popb;

    assign w_accept = i_valid && !o_stall;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    // opcode decode, unused codes act as a query
    always_comb begin
        w_is_pf   = 1'b0;
        w_is_pb   = 1'b0;
        w_is_popf = 1'b0;
        w_is_popb = 1'b0;
        unique case (i_opcode)
            OP_PUSH_FRONT: w_is_pf   = 1'b1;
            OP_PUSH_BACK:  w_is_pb   = 1'b1;
            OP_POP_FRONT:  w_is_popf = 1'b1;
            OP_POP_BACK:   w_is_popb = 1'b1;
            default: ;
        endcase
    end

    assign w_do_pf   = w_accept && w_is_pf   && !w_full;
    assign w_do_pb   = w_accept && w_is_pb   && !w_full;
    assign w_do_popf = w_accept && w_is_popf && !w_empty;
    assign w_do_popb = w_accept && w_is_popb && !w_empty;

    // push front shifts everything toward the back, pop front toward the front;
    // the back marker follows the count in both directions
    always_comb begin
        w_ctl.data_right = w_do_pf;
        w_ctl.data_left  = w_do_popf;
        w_ctl.load_back  = w_do_pb;
        w_ctl.mark_right = w_do_pf || w_do_pb;
        w_ctl.mark_left  = w_do_popf || w_do_popb;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left_data;
        logic  w_left_mark;
        t_word w_right_data;
        logic  w_right_mark;

        // cell 0 takes the pushed word from outside and is next to write when empty
        if (g == 0) begin : g_first
            assign w_left_data = i_push_value;
            assign w_left_mark = w_empty;
        end else begin : g_inner_left
            assign w_left_data = w_data[g-1];
            assign w_left_mark = w_mark[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_data = '0;
            assign w_right_mark = 1'b0;
        end else begin : g_inner_right
            assign w_right_data = w_data[g+1];
            assign w_right_mark = w_mark[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_push_value (i_push_value),
            .i_left_data  (w_left_data),
            .i_left_mark  (w_left_mark),
            .i_right_data (w_right_data),
            .i_right_mark (w_right_mark),
            .o_data       (w_data[g]),
            .o_mark       (w_mark[g]),
            .o_back_term  (w_term[g])
        );
    end

    // back word: the only marked cell wins the or-tree, zero when empty
    deq_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_term),
        .o_root (w_back)
    );

    // the tree has settled whenever the block is idle, so w_back is the
    // current back word at accept time
    assign w_finish = (r_state == S_RUN) && (r_wait == '0)
                   && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_count     = r_count;
        n_out_valid = w_finish ? 1'b1 : (r_out_valid && i_stall);

        if (w_do_pf || w_do_pb) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_popf || w_do_popb) begin
            n_count = r_count - CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_wait  = WAIT_W'(TREE_STAGES);
                end
            end
            S_RUN: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WAIT_W'(1);
                end else if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;

            if (w_accept) begin
                r_job_popped  <= w_do_popf ? w_data[0]
                               : (w_do_popb ? w_back : '0);
                r_job_pop_ok  <= w_do_popf || w_do_popb;
                r_job_dropped <= (w_is_pf || w_is_pb) && w_full;
            end

            // count and cells already hold the state after the operation
            if (w_finish) begin
                r_out_popped  <= r_job_popped;
                r_out_pop_ok  <= r_job_pop_ok;
                r_out_dropped <= r_job_dropped;
                r_out_count   <= COUNT_W'(r_count);
                r_out_empty   <= w_empty;
                r_out_full    <= w_full;
                r_out_front   <= w_empty ? '0 : w_data[0];
                r_out_back    <= w_back;
            end
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_pop_ok       = r_out_pop_ok;
    assign o_push_dropped = r_out_dropped;
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;

endmodule

/* src/deq_cell.sv */
// one storage cell of the deque chain: a word and the back marker
module deq_cell
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_word     i_push_value,
    input  t_word     i_left_data,
    input  logic      i_left_mark,
    input  t_word     i_right_data,
    input  logic      i_right_mark,
    output t_word     o_data,
    output logic      o_mark,
    output t_word     o_back_term
);

    t_word r_data;
    t_word n_data;
    logic  r_mark;
    logic  n_mark;

    always_comb begin
        n_data = r_data;
        if (i_ctl.data_right) begin
            n_data = i_left_data;
        end else if (i_ctl.data_left) begin
            n_data = i_right_data;
        end else if (i_ctl.load_back && i_left_mark) begin
            n_data = i_push_value;
        end

        n_mark = r_mark;
        if (i_ctl.mark_right) begin
            n_mark = i_left_mark;
        end else if (i_ctl.mark_left) begin
            n_mark = i_right_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else begin
            r_mark <= n_mark;
        end
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_mark      = r_mark;
    assign o_back_term = r_mark ? r_data : '0;

endmodule

/* src/deq_or_tree.sv */
// registered or-reduction tree that picks the marked back word
module deq_or_tree
    import deq_pkg::*;
#(
    parameter int N = 1024
) (
    input  logic              i_clk,
    input  logic [N-1:0][WORD_W-1:0] i_leaf,
    output t_word             o_root
);

    localparam int LEVELS = $clog2(N);
    localparam int NP     = 1 << LEVELS;
    localparam int STAGES = (LEVELS + 1) / 2;

    // register after every second level and after the root
    function automatic logic is_reg(input int lvl);
        return (lvl > 0) && ((lvl % 2 == 0) || (lvl == LEVELS));
    endfunction

    function automatic int stage_of(input int lvl);
        return (lvl < 2) ? 0 : (lvl + 1) / 2 - 1;
    endfunction

    t_word c_node [LEVELS+1][NP];
    t_word r_node [STAGES][NP];

    always_comb begin
        for (int j = 0; j < NP; j++) begin
            c_node[0][j] = (j < N) ? t_word'(i_leaf[j]) : '0;
        end
        for (int l = 1; l <= LEVELS; l++) begin
            for (int j = 0; j < NP; j++) begin
                if (j < (NP >> l)) begin
                    if (is_reg(l - 1)) begin
                        c_node[l][j] = r_node[stage_of(l - 1)][2*j]
                                     | r_node[stage_of(l - 1)][2*j + 1];
                    end else begin
                        c_node[l][j] = c_node[l-1][2*j] | c_node[l-1][2*j + 1];
                    end
                end else begin
                    c_node[l][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 1; l <= LEVELS; l++) begin
            if (is_reg(l)) begin
                r_node[stage_of(l)] <= c_node[l];
            end
        end
    end

    assign o_root = r_node[STAGES-1][0];

endmodule

/* src/deq_checker.sv */
// port-level checks on the deque results, bound to the top level
`include "double_ended_queue_defines.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input t_word              i_popped_value,
    input logic               i_pop_ok,
    input logic               i_push_dropped,
    input logic [COUNT_W-1:0] i_entry_count,
    input logic               i_is_empty,
    input logic               i_is_full,
    input t_word              i_front_value,
    input t_word              i_back_value
);

    `DEQ_ASSERT(a_hold_stalled, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_popped_value) && $stable(i_entry_count), "stalled result changed")
    `DEQ_ASSERT(a_empty_ends, i_clk, i_rst_n, i_out_valid && i_is_empty |-> i_front_value == 0 && i_back_value == 0 && i_entry_count == 0, "empty queue shows words")
    `DEQ_ASSERT(a_pop_not_full, i_clk, i_rst_n, i_out_valid && i_pop_ok |-> !i_push_dropped && !i_is_full, "pop left queue full")
    `DEQ_ASSERT(a_drop_full, i_clk, i_rst_n, i_out_valid && i_push_dropped |-> i_is_full && !i_is_empty && !i_pop_ok, "dropped push without full queue")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_stall    (i_stall),
    .i_popped_value (o_popped_value),
    .i_pop_ok       (o_pop_ok),
    .i_push_dropped (o_push_dropped),
    .i_entry_count  (o_entry_count),
    .i_is_empty     (o_is_empty),
    .i_is_full      (o_is_full),
    .i_front_value  (o_front_value),
    .i_back_value   (o_back_value)
);

/* dv/testbench.sv */
// self-checking testbench of the double-ended queue with its own item-level predictor
module testbench;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 1024;
    // the tail wait covers one item's pass through the block with room to spare
    localparam int DRAIN_CYCLES = 40;
    // slowest run: ~1300 items, each a full sender gap, a full receiver stall and
    // its pass through the block, taken several times over
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int MAX_IDLE     = 17;

    // opcodes the block does not define, all taken as a query
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam t_word WORD_MIN  = 32'sh8000_0000;
    localparam t_word WORD_MAX  = 32'sh7FFF_FFFF;
    localparam t_word WORD_ZERO = 32'sh0000_0000;
    localparam t_word WORD_ONES = 32'shFFFF_FFFF;

    // one operation waiting to be sent
    typedef struct {
        logic [OP_W-1:0] opcode;
        t_word           value;
        int              gap;             // idle cycles before it goes out
        bit              hold_for_empty;  // sent only once every result is back
    } t_deq_item;

    // one result, as the block reports it
    typedef struct packed {
        t_word              popped_value;
        logic               pop_ok;
        logic               push_dropped;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               is_full;
        t_word              front_value;
        t_word              back_value;
    } t_deq_result;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic [OP_W-1:0]    i_opcode     = OP_QUERY;
    t_word              i_push_value = WORD_ZERO;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    t_word              o_popped_value;
    logic               o_pop_ok;
    logic               o_push_dropped;
    logic [COUNT_W-1:0] o_entry_count;
    logic               o_is_empty;
    logic               o_is_full;
    t_word              o_front_value;
    t_word              o_back_value;

    double_ended_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_pop_ok       (o_pop_ok),
        .o_push_dropped (o_push_dropped),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor: circular buffer with a front index and a held count
    // ------------------------------------------------------------------
    t_word       deq_slot [CAPACITY];
    int unsigned deq_head = 0;
    int unsigned deq_held = 0;

    // buffer position at a given distance from the front
    function automatic int unsigned slot_of(int unsigned offs);
        int unsigned pos;
        pos = deq_head + offs;
        if (pos >= CAPACITY) pos -= CAPACITY;
        return pos;
    endfunction

    // applies one operation to the predicted queue and returns its result
    function automatic t_deq_result apply_deq_op(logic [OP_W-1:0] opcode, t_word value);
        t_deq_result res;
        res = '0;
        case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (deq_held >= CAPACITY) begin
                    // full: word is dropped, nothing moves
                    res.push_dropped = 1'b1;
                end else begin
                    if (opcode == OP_PUSH_FRONT) begin
                        deq_head = (deq_head == 0) ? CAPACITY - 1 : deq_head - 1;
                        deq_slot[deq_head] = value;
                    end else begin
                        deq_slot[slot_of(deq_held)] = value;
                    end
                    deq_held++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                // empty: nothing moves, pop_ok stays low and the word reads zero
                if (deq_held != 0) begin
                    if (opcode == OP_POP_FRONT) begin
                        res.popped_value = deq_slot[deq_head];
                        deq_head = slot_of(1);
                    end else begin
                        res.popped_value = deq_slot[slot_of(deq_held - 1)];
                    end
                    deq_held--;
                    res.pop_ok = 1'b1;
                end
            end
            default: ;  // query and the unused opcodes change nothing
        endcase
        if (deq_held != 0) begin
            res.front_value = deq_slot[deq_head];
            res.back_value  = deq_slot[slot_of(deq_held - 1)];
        end
        res.entry_count = COUNT_W'(deq_held);
        res.is_empty    = (deq_held == 0);
        res.is_full     = (deq_held == CAPACITY);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus plan
    // ------------------------------------------------------------------
    t_deq_item   pending_ops[$];
    t_deq_result expected_results[$];
    int          planned_held = 0;   // count only, to steer the plan toward full
    int          total_ops    = 0;
    int          accepted_cnt = 0;
    int          result_cnt   = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;

    task automatic plan_op(logic [OP_W-1:0] opcode, t_word value, bit hold);
        t_deq_item item;
        item.opcode         = opcode;
        item.value          = value;
        item.hold_for_empty = hold;
        // every fourth stretch of 50 items goes out back to back
        item.gap = ((pending_ops.size() / 50) % 4 == 3) ? 0 : $urandom_range(0, MAX_IDLE);
        pending_ops = {pending_ops, item};
        case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (planned_held < CAPACITY) planned_held++;
            OP_POP_FRONT, OP_POP_BACK:   if (planned_held > 0) planned_held--;
            default: ;
        endcase
    endtask

    // random word, with the extremes showing up now and then
    function automatic t_word rand_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_ZERO;
            3:       return WORD_ONES;
            default: return t_word'($urandom);
        endcase
    endfunction

    // random opcode: push and pop shares in percent, the rest query or unused
    function automatic logic [OP_W-1:0] rand_op(int push_pct, int pop_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (pick < push_pct + pop_pct)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (pick % 2 == 0)
            return OP_QUERY;
        return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    initial begin
        // directed: query and pops on an empty queue
        plan_op(OP_QUERY, WORD_ZERO, 1'b0);
        plan_op(OP_POP_FRONT, WORD_ONES, 1'b0);
        plan_op(OP_POP_BACK, WORD_MAX, 1'b0);
        // pushes at both ends with the extreme words; first push front wraps the head
        plan_op(OP_PUSH_FRONT, WORD_MIN, 1'b0);
        plan_op(OP_PUSH_BACK, WORD_MAX, 1'b0);
        plan_op(OP_PUSH_FRONT, WORD_ONES, 1'b0);
        plan_op(OP_PUSH_BACK, WORD_ZERO, 1'b0);
        plan_op(OP_PUSH_BACK, 32'sh5A5A_A5A5, 1'b0);
        // unused opcodes behave as a query, the value must not land anywhere
        for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
            plan_op(OP_W'(code), WORD_ONES, 1'b0);
        plan_op(OP_QUERY, WORD_MAX, 1'b0);
        // drain from both ends, then pop once more past empty
        plan_op(OP_POP_BACK, WORD_ZERO, 1'b0);
        plan_op(OP_POP_FRONT, WORD_ZERO, 1'b0);
        plan_op(OP_POP_FRONT, WORD_ZERO, 1'b0);
        plan_op(OP_POP_BACK, WORD_ZERO, 1'b0);
        plan_op(OP_POP_BACK, WORD_ZERO, 1'b0);
        plan_op(OP_POP_FRONT, WORD_ZERO, 1'b0);
        plan_op(OP_PUSH_BACK, WORD_MIN, 1'b0);
        plan_op(OP_POP_FRONT, WORD_ZERO, 1'b0);

        // random: balanced mix that keeps hitting the empty queue
        for (int n = 0; n < 80; n++)
            plan_op(rand_op(40, 45), rand_word(), n == 0 || n == 40);
        // fill to capacity from both ends, a few pops and queries mixed in
        while (planned_held < CAPACITY)
            plan_op(rand_op(94, 3), rand_word(), 1'b0);
        // pushes into a full queue are dropped
        for (int n = 0; n < 6; n++)
            plan_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word(), 1'b0);
        // hover around the full mark
        for (int n = 0; n < 40; n++)
            plan_op(rand_op(50, 45), rand_word(), n == 0);
        // pop-heavy tail
        for (int n = 0; n < 40; n++)
            plan_op(rand_op(30, 60), rand_word(), 1'b0);
        total_ops = pending_ops.size();

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every item accepted and answered, then a quiet tail for strays
        wait (accepted_cnt == total_ops && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: operation channel, changes on the falling edge
    // ------------------------------------------------------------------
    logic op_taken  = 1'b0;   // operation handshake at the last rising edge
    logic res_taken = 1'b0;   // result handshake at the last rising edge
    int   send_gap  = 0;
    int   stall_left = 0;

    always @(negedge i_clk) begin
        t_deq_item item;
        logic      next_valid;
        // a stalled item stays as it is until it is taken
        next_valid = i_valid && !op_taken;
        if (i_rst_n && !next_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].hold_for_empty && expected_results.size() != 0)) begin
                item = pending_ops[0];
                pending_ops.delete(0);
                i_opcode     <= item.opcode;
                i_push_value <= item.value;
                next_valid   = 1'b1;
                send_gap     = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
            end
        end
        i_valid <= next_valid;
    end

    // receiver stall: a fresh wait is drawn for each result taken, with
    // every third stretch of 60 results taken without any stall
    always @(negedge i_clk) begin
        if (res_taken)
            stall_left = ((result_cnt / 60) % 3 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    task automatic compare_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            if (mismatch_cnt < 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         field, result_cnt, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deq_result want;
        t_deq_result pred;
        op_taken  <= i_rst_n && i_valid && !o_stall;
        res_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n) begin
            // check first: a result never belongs to an item taken at this edge
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("result %0d arrived with no item outstanding", result_cnt);
                    mismatch_cnt++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("popped_value", want.popped_value, o_popped_value);
                    compare_field("pop_ok", want.pop_ok, o_pop_ok);
                    compare_field("push_dropped", want.push_dropped, o_push_dropped);
                    compare_field("entry_count", want.entry_count, o_entry_count);
                    compare_field("is_empty", want.is_empty, o_is_empty);
                    compare_field("is_full", want.is_full, o_is_full);
                    compare_field("front_value", want.front_value, o_front_value);
                    compare_field("back_value", want.back_value, o_back_value);
                end
                result_cnt++;
            end
            if (i_valid && !o_stall) begin
                pred = apply_deq_op(i_opcode, i_push_value);
                expected_results = {expected_results, pred};
                accepted_cnt++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
